>>> design/assert_macros.svh
// Assertion macros shared by the detector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define DTFID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DTFID_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> design/dtfid_pkg.sv
// Types and constants of the dual threshold fault interval detector
package dtfid_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned IndexW    = 32;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic signed [SampleW-1:0] LowThrReset  = -16'sd2048;
  localparam logic signed [SampleW-1:0] HighThrReset = 16'sd2048;
  localparam logic [15:0]               MinRunReset  = 16'd10;
  localparam logic                      BypassReset  = 1'b0;

  typedef enum logic [CfgIndexW-1:0] {
    CfgLowThr  = 2'd0,
    CfgHighThr = 2'd1,
    CfgMinRun  = 2'd2,
    CfgBypass  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SampleW-1:0] low_threshold;
    logic signed [SampleW-1:0] high_threshold;
    logic [15:0]               min_run_length;
    logic                      bypass_min_length;
  } cfg_t;

  typedef struct packed {
    logic              channel;
    logic [IndexW-1:0] run_start;
    logic [IndexW-1:0] run_end;
    logic              last_of_item;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

>>> design/dual_threshold_fault_interval_detector.sv
// Top level of the dual threshold fault interval detector
//
// Slave stream: one item per beat, two signed Q4.12 detector samples.
// Master stream: one item per reported run: channel in tuser, start and end
// sample index in tdata, tlast on the final result caused by one sample.
// Configuration: cfg_we_i writes cfg_data_i to the register cfg_index_i
// (0 low threshold, 1 high threshold, 2 minimum run length, 3 bypass).
// An accepted sample passes the input register, then the result queue,
// before its results raise m_axis_tvalid; the input register holds it while
// the queue lacks room.
// Throughput: one sample per cycle while each sample closes at most one
// run; a sample closing both runs queues two results, which leave one per beat. The
// result queue (Depth entries) sets how long the slave side keeps taking
// items while the master side stalls; s_axis_tready falls while the input
// register holds an item and fewer than two queue entries would be free.
// No result is ever dropped.
// Reset clears the sample index, both run flags and the queue, and loads
// the register defaults (-0.5, +0.5, 10 samples, bypass off).
// Runs still open when the input stops are never reported.
module dual_threshold_fault_interval_detector #(
  parameter int unsigned FifoDepth = dtfid_pkg::FifoDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // sample_one, sample_two
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [63:0]                     m_axis_tdata,  // run_start, run_end
  output logic                            m_axis_tlast,  // last_of_item
  output logic                            m_axis_tuser,  // channel
  input  logic                            cfg_we_i,
  input  logic [dtfid_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [dtfid_pkg::CfgDataW-1:0]  cfg_data_i
);

  dtfid_pkg::cfg_t    cfg;
  dtfid_pkg::push_t   push;
  dtfid_pkg::result_t res;
  logic               room;

  dtfid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dtfid_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_one_i (s_axis_tdata[15:0]),
    .sample_two_i (s_axis_tdata[31:16]),
    .cfg_i        (cfg),
    .room_i       (room),
    .push_o       (push)
  );

  dtfid_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {res.run_end, res.run_start};
  assign m_axis_tlast = res.last_of_item;
  assign m_axis_tuser = res.channel;

endmodule

>>> design/dtfid_cfg_regs.sv
// Configuration registers of the detector
module dtfid_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dtfid_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [dtfid_pkg::CfgDataW-1:0]  cfg_data_i,
  output dtfid_pkg::cfg_t                cfg_o
);

  dtfid_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dtfid_pkg::cfg_reg_e'(cfg_index_i))
        dtfid_pkg::CfgLowThr:  cfg_d.low_threshold     = cfg_data_i;
        dtfid_pkg::CfgHighThr: cfg_d.high_threshold    = cfg_data_i;
        dtfid_pkg::CfgMinRun:  cfg_d.min_run_length    = cfg_data_i;
        dtfid_pkg::CfgBypass:  cfg_d.bypass_min_length = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold     <= dtfid_pkg::LowThrReset;
      cfg_q.high_threshold    <= dtfid_pkg::HighThrReset;
      cfg_q.min_run_length    <= dtfid_pkg::MinRunReset;
      cfg_q.bypass_min_length <= dtfid_pkg::BypassReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/dtfid_eval.sv
// Input register, run tracking state and result generation
`include "assert_macros.svh"

module dtfid_eval (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [dtfid_pkg::SampleW-1:0] sample_one_i,
  input  logic signed [dtfid_pkg::SampleW-1:0] sample_two_i,
  input  dtfid_pkg::cfg_t                     cfg_i,
  input  logic                                room_i,
  output dtfid_pkg::push_t                    push_o
);

  logic                                in_valid_q, in_valid_d;
  logic signed [dtfid_pkg::SampleW-1:0] s1_q, s2_q;
  logic [dtfid_pkg::IndexW-1:0]        sample_index_q, sample_index_d;
  logic                                active_one_q, active_one_d;
  logic                                active_two_q, active_two_d;
  logic [dtfid_pkg::IndexW-1:0]        start_one_q, start_one_d;
  logic [dtfid_pkg::IndexW-1:0]        start_two_q, start_two_d;

  logic fire, accept;
  logic hit1, hit2, keep1, keep2;
  logic [dtfid_pkg::IndexW-1:0] len1, len2, min_len;
  dtfid_pkg::result_t r1, r2;

  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hit1    = s1_q < cfg_i.low_threshold;
  assign hit2    = s2_q > cfg_i.high_threshold;
  assign len1    = sample_index_q - start_one_q;
  assign len2    = sample_index_q - start_two_q;
  assign min_len = {{(dtfid_pkg::IndexW-16){1'b0}}, cfg_i.min_run_length};
  assign keep1   = active_one_q && !hit1 && (cfg_i.bypass_min_length || len1 >= min_len);
  assign keep2   = active_two_q && !hit2 && (cfg_i.bypass_min_length || len2 >= min_len);

  always_comb begin
    r1.channel      = 1'b0;
    r1.run_start    = start_one_q;
    r1.run_end      = sample_index_q;
    r1.last_of_item = !keep2;
    r2.channel      = 1'b1;
    r2.run_start    = start_two_q;
    r2.run_end      = sample_index_q;
    r2.last_of_item = 1'b1;

    push_o.res0  = keep1 ? r1 : r2;
    push_o.res1  = r2;
    push_o.count = fire ? ({1'b0, keep1} + {1'b0, keep2}) : 2'd0;
  end

  always_comb begin
    in_valid_d     = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
    sample_index_d = sample_index_q;
    active_one_d   = active_one_q;
    active_two_d   = active_two_q;
    start_one_d    = start_one_q;
    start_two_d    = start_two_q;
    if (fire) begin
      sample_index_d = sample_index_q + 1'b1;
      active_one_d   = hit1;
      active_two_d   = hit2;
      if (hit1 && !active_one_q) begin
        start_one_d = sample_index_q;
      end
      if (hit2 && !active_two_q) begin
        start_two_d = sample_index_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      sample_index_q <= '0;
      active_one_q   <= 1'b0;
      active_two_q   <= 1'b0;
      start_one_q    <= '0;
      start_two_q    <= '0;
    end else begin
      in_valid_q     <= in_valid_d;
      sample_index_q <= sample_index_d;
      active_one_q   <= active_one_d;
      active_two_q   <= active_two_d;
      start_one_q    <= start_one_d;
      start_two_q    <= start_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= sample_one_i;
      s2_q <= sample_two_i;
    end
  end

  // paired results: channel one leads and does not close the item
  `DTFID_ASSERT(a_pair_order,
      push_o.count == 2'd2 |-> (!push_o.res0.channel && !push_o.res0.last_of_item
                                && push_o.res1.channel),
      "two results not in channel order")
  `DTFID_ASSERT_NEXT(a_index_step, fire,
      sample_index_q == $past(sample_index_q) + 32'd1,
      "sample index did not advance")
  `DTFID_ASSERT_NEXT(a_start_on_open, fire && hit1 && !active_one_q,
      active_one_q && start_one_q == $past(sample_index_q),
      "channel one run opened with wrong start")

endmodule

>>> design/dtfid_result_fifo.sv
// Result queue taking up to two results per cycle, one out per cycle while out_ready_i is high
`include "assert_macros.svh"

module dtfid_result_fifo #(
  parameter int unsigned Depth = dtfid_pkg::FifoDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtfid_pkg::push_t   push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dtfid_pkg::result_t out_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  dtfid_pkg::result_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntW-1:0] count_q, count_d, level;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != '0;
  assign out_o       = mem_q[rd_ptr_q];
  assign level       = count_q - CntW'(pop);
  assign room_o      = level <= CntW'(Depth - 2);
  assign wr_ptr_nx   = ptr_inc(wr_ptr_q);

  always_comb begin
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case (push_i.count)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  `DTFID_ASSERT(a_count_bound, count_q <= CntW'(Depth), "result queue over depth")
  `DTFID_ASSERT(a_no_overflow,
      push_i.count != 2'd0 |-> (level + CntW'(push_i.count) <= CntW'(Depth)),
      "result queue overflow")

endmodule

>>> verif/testbench.sv
// Stream testbench for the dual threshold fault interval detector, with a run predictor
`timescale 1ns / 100ps

module testbench;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata;  // sample_one, sample_two
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [63:0]                     m_axis_tdata;  // run_start, run_end
  logic                            m_axis_tlast;  // last_of_item
  logic                            m_axis_tuser;  // channel
  logic                            cfg_we_i;
  logic [dtfid_pkg::CfgIndexW-1:0] cfg_index_i;
  logic [dtfid_pkg::CfgDataW-1:0]  cfg_data_i;

  dual_threshold_fault_interval_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // register mirror
  logic signed [15:0] thr_low;
  logic signed [15:0] thr_high;
  logic [15:0]        min_len;
  logic               bypass_on;

  // run tracker state
  logic [31:0] run_index;
  logic        open_one;
  logic        open_two;
  logic [31:0] from_one;
  logic [31:0] from_two;

  logic [31:0]        sample_q[$];
  dtfid_pkg::result_t runs_due[$];
  int                 items_pushed;
  int                 items_accepted;
  int                 errors;
  logic               in_taken;
  logic               no_gaps;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic logic keep_run(input logic [31:0] from_idx);
    return bypass_on || ((run_index - from_idx) >= {16'd0, min_len});
  endfunction

  task automatic predict_runs(input logic [31:0] pair);
    logic signed [15:0] s_one;
    logic signed [15:0] s_two;
    dtfid_pkg::result_t found[2];
    int                 n;
    s_one = pair[15:0];
    s_two = pair[31:16];
    n = 0;
    if (s_one < thr_low) begin
      if (!open_one) begin
        open_one = 1'b1;
        from_one = run_index;
      end
    end else if (open_one) begin
      open_one = 1'b0;
      if (keep_run(from_one)) begin
        found[n] = '{1'b0, from_one, run_index, 1'b0};
        n++;
      end
    end
    if (s_two > thr_high) begin
      if (!open_two) begin
        open_two = 1'b1;
        from_two = run_index;
      end
    end else if (open_two) begin
      open_two = 1'b0;
      if (keep_run(from_two)) begin
        found[n] = '{1'b1, from_two, run_index, 1'b0};
        n++;
      end
    end
    if (n > 0) found[n-1].last_of_item = 1'b1;
    for (int i = 0; i < n; i++) runs_due.push_back(found[i]);
    run_index = run_index + 32'd1;
  endtask

  task automatic check_run(input dtfid_pkg::result_t got);
    dtfid_pkg::result_t want;
    if (runs_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected run: ch %0d start %0d end %0d last %0d",
                 got.channel, got.run_start, got.run_end, got.last_of_item);
    end else begin
      want = runs_due.pop_front();
      if (got.channel !== want.channel || got.run_start !== want.run_start ||
          got.run_end !== want.run_end || got.last_of_item !== want.last_of_item) begin
        errors++;
        if (errors <= 10)
          $display("run mismatch (ch/start/end/last): exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   want.channel, want.run_start, want.run_end, want.last_of_item,
                   got.channel, got.run_start, got.run_end, got.last_of_item);
      end
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (sample_q.size() != 0 && (no_gaps || $urandom_range(99) >= 17)) begin
        s_axis_tdata  <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 17);
  end

  // monitor
  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        check_run('{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast});
      if (s_axis_tvalid && s_axis_tready) begin
        predict_runs(s_axis_tdata);
        items_accepted++;
      end
    end
  end

  task automatic queue_pair(input logic [15:0] one, input logic [15:0] two);
    sample_q.push_back({two, one});
    items_pushed++;
  endtask

  task automatic set_config(input logic [15:0] low, input logic [15:0] high,
                            input logic [15:0] min_run, input logic bypass);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dtfid_pkg::CfgLowThr;
    cfg_data_i  <= low;
    @(negedge clk_i);
    cfg_index_i <= dtfid_pkg::CfgHighThr;
    cfg_data_i  <= high;
    @(negedge clk_i);
    cfg_index_i <= dtfid_pkg::CfgMinRun;
    cfg_data_i  <= min_run;
    @(negedge clk_i);
    cfg_index_i <= dtfid_pkg::CfgBypass;
    cfg_data_i  <= {15'd0, bypass};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_low   = low;
    thr_high  = high;
    min_len   = min_run;
    bypass_on = bypass;
  endtask

  task automatic wait_drained;
    while (items_accepted != items_pushed || runs_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_between(input int lo, input int hi);
    if ($urandom_range(4) == 0) return $urandom_range(1) ? lo[15:0] : hi[15:0];
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // runs of random length on each channel, with some noise items
  task automatic run_random(input int count);
    int seg_max;
    int left_one;
    int left_two;
    logic want_one;
    logic want_two;
    logic [15:0] one;
    logic [15:0] two;
    seg_max  = (min_len < 12) ? 2 * int'(min_len) + 3 : 14;
    left_one = 0;
    left_two = 0;
    want_one = 1'b0;
    want_two = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (left_one == 0) begin
        want_one = 1'($urandom_range(1));
        left_one = $urandom_range(seg_max, 1);
      end
      if (left_two == 0) begin
        want_two = 1'($urandom_range(1));
        left_two = $urandom_range(seg_max, 1);
      end
      left_one--;
      left_two--;
      if (want_one && int'(thr_low) > -32768) one = pick_between(-32768, int'(thr_low) - 1);
      else one = pick_between(int'(thr_low), 32767);
      if (want_two && int'(thr_high) < 32767) two = pick_between(int'(thr_high) + 1, 32767);
      else two = pick_between(-32768, int'(thr_high));
      if ($urandom_range(99) < 8) begin
        one = 16'($urandom);
        two = 16'($urandom);
      end
      queue_pair(one, two);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = dtfid_pkg::CfgLowThr;
    cfg_data_i     = '0;
    in_taken       = 1'b0;
    no_gaps        = 1'b0;
    items_pushed   = 0;
    items_accepted = 0;
    errors         = 0;
    thr_low        = dtfid_pkg::LowThrReset;
    thr_high       = dtfid_pkg::HighThrReset;
    min_len        = dtfid_pkg::MinRunReset;
    bypass_on      = dtfid_pkg::BypassReset;
    run_index      = '0;
    open_one       = 1'b0;
    open_two       = 1'b0;
    from_one       = '0;
    from_two       = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: samples equal to the thresholds, short run dropped,
    // run of exactly the minimum kept, channels closing apart
    queue_pair(16'hF800, 16'h0800);
    repeat (3) queue_pair(16'h8000, 16'h7FFF);
    queue_pair(16'h7FFF, 16'h8000);
    for (int k = 0; k < 10; k++)
      if (k % 2 == 0) queue_pair(16'hF7FF, 16'h0801);
      else queue_pair(16'h8000, 16'h7FFF);
    queue_pair(16'hF800, 16'h7FFF);
    queue_pair(16'h0000, 16'h0800);
    wait_drained();

    // bypass: one-sample runs, both channels closing on the same sample
    set_config(dtfid_pkg::LowThrReset, dtfid_pkg::HighThrReset, 16'hFFFF, 1'b1);
    queue_pair(16'h8000, 16'h7FFF);
    queue_pair(16'hFFFF, 16'h0000);
    queue_pair(16'h0000, 16'h0000);
    wait_drained();

    set_config(-16'sd1000, 16'sd1000, 16'd4, 1'b0);
    run_random(120);
    wait_drained();

    no_gaps = 1'b1;
    set_config(16'd0, 16'd0, 16'd0, 1'b0);
    run_random(80);
    wait_drained();
    no_gaps = 1'b0;

    // neither channel can open
    set_config(16'h8000, 16'h7FFF, 16'd1, 1'b0);
    run_random(30);
    wait_drained();

    // both channels open almost always
    set_config(16'h7FFF, 16'h8000, 16'd3, 1'b0);
    run_random(60);
    wait_drained();

    set_config(16'sd100, -16'sd100, 16'hFFFF, 1'b1);
    run_random(80);
    wait_drained();

    // every run too short
    set_config(-16'sd5, 16'sd7, 16'hFFFF, 1'b0);
    run_random(40);
    wait_drained();

    set_config(dtfid_pkg::LowThrReset, dtfid_pkg::HighThrReset, dtfid_pkg::MinRunReset, 1'b0);
    run_random(140);
    wait_drained();

    if (errors == 0 && runs_due.size() == 0) begin
      $display("dual_threshold_fault_interval_detector test passed");
    end else begin
      $display("dual_threshold_fault_interval_detector test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("dual_threshold_fault_interval_detector test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/dtfid_pkg.sv
design/dtfid_cfg_regs.sv
design/dtfid_eval.sv
design/dtfid_result_fifo.sv
design/dual_threshold_fault_interval_detector.sv
verif/testbench.sv
